// ===== rtl/core/pprk_pkg.sv =====
// ----------------------------------------------------------------------------
// pprk_pkg
// Shared types and constants for the k-permutation rank/unrank pipeline.
// ----------------------------------------------------------------------------
package pprk_pkg;

    localparam int LOC_FIELDS      = 8;
    localparam int LOC_IDX_W       = $clog2(LOC_FIELDS);
    localparam int CELL_W          = 4;
    localparam int IDX_W           = 32;
    localparam int TC_W            = 4;
    localparam int RADIX_W         = 6;
    localparam int BOARD_CELLS_DEF = 16;
    localparam int MAX_TILES_DEF   = 8;

    localparam logic [TC_W-1:0] TILE_COUNT_RST = TC_W'(8);

    typedef logic [CELL_W-1:0] t_cell;

    typedef struct packed {
        logic                        func;
        logic [TC_W-1:0]             k;
        logic [IDX_W-1:0]            acc;
        logic [IDX_W-1:0]            aux;
        t_cell [LOC_FIELDS-1:0]      cells;
        t_cell                       blank;
    } t_pipe;

    // floor((2^32 - 1) / r): estimate of x / r is low by at most one
    function automatic logic [IDX_W-1:0] recip(input logic [RADIX_W-1:0] r);
        logic [IDX_W-1:0] m;
        begin
            case (r)
                6'd1:    m = 32'hFFFF_FFFF;
                6'd2:    m = 32'h7FFF_FFFF;
                6'd3:    m = 32'h5555_5555;
                6'd4:    m = 32'h3FFF_FFFF;
                6'd5:    m = 32'h3333_3333;
                6'd6:    m = 32'h2AAA_AAAA;
                6'd7:    m = 32'h2492_4924;
                6'd8:    m = 32'h1FFF_FFFF;
                6'd9:    m = 32'h1C71_C71C;
                6'd10:   m = 32'h1999_9999;
                6'd11:   m = 32'h1745_D174;
                6'd12:   m = 32'h1555_5555;
                6'd13:   m = 32'h13B1_3B13;
                6'd14:   m = 32'h1249_2492;
                6'd15:   m = 32'h1111_1111;
                6'd16:   m = 32'h0FFF_FFFF;
                default: m = '0;
            endcase
            return m;
        end
    endfunction

endpackage

// ===== rtl/core/pprk_if.sv =====
// ----------------------------------------------------------------------------
// pprk_in_if / pprk_out_if
// Valid/ready channels carrying a request and a result transaction.
// ----------------------------------------------------------------------------
interface pprk_in_if;
    import pprk_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 func;
    logic [IDX_W-1:0]     index_in;
    logic [CELL_W-1:0]    blank_in;
    logic [CELL_W-1:0]    loc_in_0;
    logic [CELL_W-1:0]    loc_in_1;
    logic [CELL_W-1:0]    loc_in_2;
    logic [CELL_W-1:0]    loc_in_3;
    logic [CELL_W-1:0]    loc_in_4;
    logic [CELL_W-1:0]    loc_in_5;
    logic [CELL_W-1:0]    loc_in_6;
    logic [CELL_W-1:0]    loc_in_7;

    modport source (output valid, func, index_in, blank_in, loc_in_0, loc_in_1, loc_in_2,
                    loc_in_3, loc_in_4, loc_in_5, loc_in_6, loc_in_7, input ready);
    modport sink   (input valid, func, index_in, blank_in, loc_in_0, loc_in_1, loc_in_2,
                    loc_in_3, loc_in_4, loc_in_5, loc_in_6, loc_in_7, output ready);
endinterface

interface pprk_out_if;
    import pprk_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [IDX_W-1:0]     index_out;
    logic [CELL_W-1:0]    blank_out;
    logic [CELL_W-1:0]    loc_out_0;
    logic [CELL_W-1:0]    loc_out_1;
    logic [CELL_W-1:0]    loc_out_2;
    logic [CELL_W-1:0]    loc_out_3;
    logic [CELL_W-1:0]    loc_out_4;
    logic [CELL_W-1:0]    loc_out_5;
    logic [CELL_W-1:0]    loc_out_6;
    logic [CELL_W-1:0]    loc_out_7;

    modport source (output valid, index_out, blank_out, loc_out_0, loc_out_1, loc_out_2,
                    loc_out_3, loc_out_4, loc_out_5, loc_out_6, loc_out_7, input ready);
    modport sink   (input valid, index_out, blank_out, loc_out_0, loc_out_1, loc_out_2,
                    loc_out_3, loc_out_4, loc_out_5, loc_out_6, loc_out_7, output ready);
endinterface

// ===== rtl/core/pprk_stage.sv =====
// ----------------------------------------------------------------------------
// pprk_stage
// One registered pipeline stage. Its position selects the work: a rank step
// or a digit divide half in the front, a cell restore step in the back.
// ----------------------------------------------------------------------------
module pprk_stage #(
    parameter int STAGE       = 0,
    parameter int BOARD_CELLS = pprk_pkg::BOARD_CELLS_DEF,
    parameter int K_MAX       = pprk_pkg::MAX_TILES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  pprk_pkg::t_pipe i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output pprk_pkg::t_pipe o_data
);
    import pprk_pkg::*;

    localparam int DIV_STAGES = 2 * (K_MAX + 1);
    localparam int SLOT       = STAGE / 2;
    localparam int HALF       = STAGE % 2;
    localparam int RSLOT      = STAGE - DIV_STAGES;

    localparam logic [TC_W-1:0]      SLOT_K     = TC_W'(SLOT);
    localparam logic [TC_W-1:0]      RSLOT_K    = TC_W'(RSLOT);
    localparam logic [LOC_IDX_W-1:0] SLOT_I     = LOC_IDX_W'(SLOT);
    localparam logic [RADIX_W-1:0]   STEP_RADIX = RADIX_W'(BOARD_CELLS - 1 - SLOT);
    localparam logic [RADIX_W-1:0]   BASE_RADIX = RADIX_W'(BOARD_CELLS + SLOT);

    logic  r_valid;
    t_pipe r_data;
    t_pipe n_data;

    always_comb begin
        logic [RADIX_W-1:0]  radix;
        logic [2*IDX_W-1:0]  prod;
        logic [IDX_W-1:0]    rem;
        logic [IDX_W-1:0]    q;
        logic [TC_W-1:0]     pos;
        t_cell               ci;
        n_data = i_data;
        radix  = BASE_RADIX - RADIX_W'(i_data.k);
        prod   = '0;
        rem    = '0;
        q      = '0;
        pos    = '0;
        ci     = '0;
        if (STAGE < DIV_STAGES) begin
            if (!i_data.func) begin
                if (HALF == 0) begin
                    if (SLOT < K_MAX) begin
                        if (SLOT_K < i_data.k) begin
                            ci = i_data.cells[SLOT_I];
                            n_data.acc = IDX_W'((i_data.acc + IDX_W'(ci)) * STEP_RADIX);
                            for (int j = 0; j < LOC_FIELDS; j++) begin
                                if (j > SLOT && TC_W'(j) < i_data.k &&
                                    ci < i_data.cells[j]) begin
                                    n_data.cells[j] = i_data.cells[j] - 1'b1;
                                end
                            end
                            if (ci < i_data.blank) begin
                                n_data.blank = i_data.blank - 1'b1;
                            end
                        end
                    end else begin
                        n_data.acc = i_data.acc + IDX_W'(i_data.blank);
                    end
                end
            end else if (SLOT_K <= i_data.k) begin
                if (HALF == 0) begin
                    prod       = (2*IDX_W)'(i_data.acc) * (2*IDX_W)'(recip(radix));
                    n_data.aux = i_data.acc;
                    n_data.acc = prod[2*IDX_W-1:IDX_W];
                end else begin
                    q   = i_data.acc;
                    rem = i_data.aux - IDX_W'(i_data.acc * radix);
                    if (rem >= IDX_W'(radix)) begin
                        q   = q + 1'b1;
                        rem = rem - IDX_W'(radix);
                    end
                    n_data.acc = q;
                    if (SLOT == 0) begin
                        n_data.blank = rem[CELL_W-1:0];
                    end else begin
                        pos = i_data.k - SLOT_K;
                        n_data.cells[pos[LOC_IDX_W-1:0]] = rem[CELL_W-1:0];
                    end
                end
            end
        end else begin
            if (i_data.func && RSLOT_K < i_data.k) begin
                pos = i_data.k - 1'b1 - RSLOT_K;
                ci  = i_data.cells[pos[LOC_IDX_W-1:0]];
                for (int j = 0; j < LOC_FIELDS; j++) begin
                    if (TC_W'(j) > pos && TC_W'(j) < i_data.k && ci <= i_data.cells[j]) begin
                        n_data.cells[j] = i_data.cells[j] + 1'b1;
                    end
                end
                if (ci <= i_data.blank) begin
                    n_data.blank = i_data.blank + 1'b1;
                end
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/core/partial_permutation_rank_unrank_top.sv =====
// ----------------------------------------------------------------------------
// partial_permutation_rank_unrank_top
// Pipeline: registered stages for rank steps, divide halves and restores,
// K_MAX = min(MAX_TILES, 8, BOARD_CELLS-1). Throughput: one transaction per
// cycle unless o_result stalls; every stage has its own valid/ready.
// Reset: synchronous, active low; empties the pipe, tile_count returns to 8.
// ----------------------------------------------------------------------------
module partial_permutation_rank_unrank_top #(
    parameter int BOARD_CELLS = pprk_pkg::BOARD_CELLS_DEF,
    parameter int MAX_TILES   = pprk_pkg::MAX_TILES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [pprk_pkg::TC_W-1:0] i_cfg_wdata,
    pprk_in_if.sink                   i_item,
    pprk_out_if.source                o_result
);
    import pprk_pkg::*;

    localparam int K_LIM1     = (MAX_TILES < LOC_FIELDS) ? MAX_TILES : LOC_FIELDS;
    localparam int K_MAX      = (K_LIM1 < BOARD_CELLS - 1) ? K_LIM1 : BOARD_CELLS - 1;
    localparam int NUM_STAGES = 3 * K_MAX + 2;

    logic [TC_W-1:0]       r_tile_count;
    logic [TC_W-1:0]       k_eff;
    logic [NUM_STAGES:0]   valid;
    logic [NUM_STAGES:0]   ready;
    t_pipe                 data [0:NUM_STAGES];
    t_pipe                 last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_count <= TILE_COUNT_RST;
        end else if (i_cfg_we) begin
            r_tile_count <= i_cfg_wdata;
        end
    end

    assign k_eff = (r_tile_count > TC_W'(K_MAX)) ? TC_W'(K_MAX) : r_tile_count;

    always_comb begin
        data[0].func  = i_item.func;
        data[0].k     = k_eff;
        data[0].acc   = i_item.func ? i_item.index_in : '0;
        data[0].aux   = '0;
        data[0].blank = i_item.func ? '0 : i_item.blank_in;
        data[0].cells = i_item.func ? '0 :
            {i_item.loc_in_7, i_item.loc_in_6, i_item.loc_in_5, i_item.loc_in_4,
             i_item.loc_in_3, i_item.loc_in_2, i_item.loc_in_1, i_item.loc_in_0};
    end

    assign valid[0]     = i_item.valid;
    assign i_item.ready = ready[0];

    for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
        pprk_stage #(
            .STAGE       (s),
            .BOARD_CELLS (BOARD_CELLS),
            .K_MAX       (K_MAX)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (valid[s]),
            .o_ready (ready[s]),
            .i_data  (data[s]),
            .o_valid (valid[s+1]),
            .i_ready (ready[s+1]),
            .o_data  (data[s+1])
        );
    end

    assign last              = data[NUM_STAGES];
    assign ready[NUM_STAGES] = o_result.ready;
    assign o_result.valid    = valid[NUM_STAGES];

    assign o_result.index_out = last.func ? '0 : last.acc;
    assign o_result.blank_out = last.func ? last.blank : '0;
    assign o_result.loc_out_0 = last.func ? last.cells[0] : '0;
    assign o_result.loc_out_1 = last.func ? last.cells[1] : '0;
    assign o_result.loc_out_2 = last.func ? last.cells[2] : '0;
    assign o_result.loc_out_3 = last.func ? last.cells[3] : '0;
    assign o_result.loc_out_4 = last.func ? last.cells[4] : '0;
    assign o_result.loc_out_5 = last.func ? last.cells[5] : '0;
    assign o_result.loc_out_6 = last.func ? last.cells[6] : '0;
    assign o_result.loc_out_7 = last.func ? last.cells[7] : '0;

endmodule

// ===== rtl/core/pprk_checker.sv =====
// ----------------------------------------------------------------------------
// pprk_checker
// Port-level checks on the rank/unrank top level, attached by bind.
// ----------------------------------------------------------------------------
module pprk_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [pprk_pkg::IDX_W-1:0]  i_index_out,
    input logic [pprk_pkg::CELL_W-1:0] i_blank_out,
    input logic [pprk_pkg::CELL_W-1:0] i_loc_out_0
);
    import pprk_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_ready_after_reset: assert property (@(posedge i_clk) $past(!i_rst_n) |-> i_in_ready)
        else $error("input not ready with empty pipe");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_index_out))
        else $error("stalled result transaction changed");

    a_mode_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_index_out != '0 |-> i_blank_out == '0 && i_loc_out_0 == '0)
        else $error("rank and unrank fields both nonzero");

endmodule

bind partial_permutation_rank_unrank_top pprk_checker u_pprk_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_index_out (o_result.index_out),
    .i_blank_out (o_result.blank_out),
    .i_loc_out_0 (o_result.loc_out_0)
);
